FILE: sv/msb_pkg.sv
// Shared types and constants for the mesh bilinear sampler.
// No dependencies; every module of the block imports this package.
package msb_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_HALF_EXTENT = 1'b0;
  localparam logic REG_CELL_SCALE  = 1'b1;

  localparam int CFG_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int WEIGHT_W = 16;

  localparam logic [CFG_W-1:0] HALF_EXTENT_RST = 31'd65536;
  localparam logic [CFG_W-1:0] CELL_SCALE_RST  = 31'd4194304;

  // One in Q0.16 weight units, one bit wider than a weight.
  localparam logic [WEIGHT_W:0] WEIGHT_ONE = 17'd65536;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/msb_front.sv
// Front end of the sampler: accepts requests, maps query points to cell
// indices and weights, and pushes classified requests into the queue. Uses msb_pkg.
module msb_front import msb_pkg::*; #(
  parameter int MESH_SIZE,
  parameter int IW,
  parameter int QW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [6:0]                 in_cell_x,
  input  logic [6:0]                 in_cell_y,
  input  logic signed [VALUE_W-1:0]  in_cell_value,
  input  logic signed [VALUE_W-1:0]  in_query_x,
  input  logic signed [VALUE_W-1:0]  in_query_y,
  input  logic [CFG_W-1:0]           half_extent,
  input  logic [CFG_W-1:0]           cell_scale,
  input  q_status_t                  q_st,
  output logic                       q_push,
  output logic [QW-1:0]              q_entry
);

  logic                      a_v_r, a_cmd_r;
  logic [6:0]                a_cx_r, a_cy_r;
  logic [VALUE_W-1:0]        a_val_r;
  logic signed [32:0]        a_sx_r, a_sy_r;
  logic                      b_v_r, b_cmd_r;
  logic [6:0]                b_cx_r, b_cy_r;
  logic [VALUE_W-1:0]        b_val_r;
  logic signed [63:0]        b_px_r, b_py_r;

  logic                      a_ready, b_ready;
  logic signed [32:0]        sx_nxt, sy_nxt, scale_s;
  logic signed [64:0]        mx, my;
  logic [31:0]               hi_x, hi_y;
  logic                      ok_x, ok_y, ok_wr, ok;
  logic [IW-1:0]             ex, ey;

  assign b_ready  = !b_v_r || !q_st.full;
  assign a_ready  = !a_v_r || b_ready;
  assign in_stall = !a_ready;
  assign q_push   = b_v_r && !q_st.full;

  assign sx_nxt  = $signed({in_query_x[31], in_query_x}) + $signed({2'b00, half_extent});
  assign sy_nxt  = $signed({in_query_y[31], in_query_y}) + $signed({2'b00, half_extent});
  assign scale_s = $signed({2'b00, cell_scale});

  always_comb begin
    mx = a_sx_r * scale_s;
    my = a_sy_r * scale_s;
  end

  // Integer part of u is the cell index plus one; it must land in 2..N-1.
  assign hi_x  = b_px_r[63:32];
  assign hi_y  = b_py_r[63:32];
  assign ok_x  = !b_px_r[63] && (hi_x >= 32'd2) && (hi_x <= 32'(MESH_SIZE - 1));
  assign ok_y  = !b_py_r[63] && (hi_y >= 32'd2) && (hi_y <= 32'(MESH_SIZE - 1));
  assign ok_wr = (32'(b_cx_r) < 32'(MESH_SIZE)) && (32'(b_cy_r) < 32'(MESH_SIZE));

  always_comb begin
    if (b_cmd_r == CMD_WRITE) begin
      ok = ok_wr;
      ex = IW'(b_cx_r);
      ey = IW'(b_cy_r);
    end else begin
      ok = ok_x && ok_y;
      ex = IW'(hi_x - 32'd1);
      ey = IW'(hi_y - 32'd1);
    end
  end

  assign q_entry = {b_cmd_r, ok, ex, ey, b_px_r[31:16], b_py_r[31:16], b_val_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= in_valid;
      if (b_ready) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_cmd_r <= in_command;
      a_cx_r  <= in_cell_x;
      a_cy_r  <= in_cell_y;
      a_val_r <= in_cell_value;
      a_sx_r  <= sx_nxt;
      a_sy_r  <= sy_nxt;
    end
    if (b_ready && a_v_r) begin
      b_cmd_r <= a_cmd_r;
      b_cx_r  <= a_cx_r;
      b_cy_r  <= a_cy_r;
      b_val_r <= a_val_r;
      b_px_r  <= mx[63:0];
      b_py_r  <= my[63:0];
    end
  end

endmodule

FILE: sv/msb_queue.sv
// Short request queue between the front and back ends of the sampler.
// Register based; uses msb_pkg for the status struct.
module msb_queue import msb_pkg::*; #(
  parameter int W,
  parameter int DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  input  logic          pop,
  output logic [W-1:0]  pop_data,
  output q_status_t     st
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0] count_r;
  logic           do_push, do_pop;

  assign st.full  = (count_r == CNW'(DEPTH));
  assign st.empty = (count_r == '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: sv/msb_back.sv
// Back end of the sampler: holds the mesh in four parity banks, performs
// cell writes and the four-tap bilinear blend. Uses msb_pkg.
module msb_back import msb_pkg::*; #(
  parameter int MESH_SIZE,
  parameter int IW,
  parameter int QW
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [QW-1:0]             q_entry,
  input  q_status_t                 q_st,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_sample_value,
  output logic                      out_in_range
);

  // Bank (bx, by) holds the cells whose column parity is bx and row parity by,
  // so the four neighbours of any cell land in four different banks.
  localparam int HALF    = (MESH_SIZE + 1) / 2;
  localparam int BDEPTH  = HALF * HALF;
  localparam int AW      = $clog2(BDEPTH);

  logic                 e_cmd, e_ok;
  logic [IW-1:0]        e_x, e_y;
  logic [WEIGHT_W-1:0]  e_p, e_q;
  logic [VALUE_W-1:0]   e_data;

  logic                 c_v_r, c_ok_r, c_x0_r, c_y0_r;
  logic [WEIGHT_W-1:0]  c_p_r, c_q_r;
  logic [VALUE_W-1:0]   rd_r [4];
  logic                 d_v_r, d_ok_r;
  logic [32:0]          d_w_r [4];
  logic signed [VALUE_W-1:0] d_val_r [4];
  logic                 e_v_r, e_ok_r;
  logic signed [63:0]   e_m_r [4];
  logic                 o_v_r, o_ok_r;
  logic signed [VALUE_W-1:0] o_val_r;

  logic                 o_ready, e_ready, d_ready, c_ready;
  logic [AW-1:0]        rd_addr [4];
  logic [AW-1:0]        wr_addr;
  logic [1:0]           wr_bank;
  logic                 wr_en;
  logic [WEIGHT_W:0]    wp0, wp1, wq0, wq1;
  logic [33:0]          w00, w10, w01, w11;
  logic signed [65:0]   m_nxt [4];
  logic signed [63:0]   sum;

  assign {e_cmd, e_ok, e_x, e_y, e_p, e_q, e_data} = q_entry;

  assign o_ready = !o_v_r || !out_stall;
  assign e_ready = !e_v_r || o_ready;
  assign d_ready = !d_v_r || e_ready;
  assign c_ready = !c_v_r || d_ready;
  assign q_pop   = !q_st.empty && c_ready;

  function automatic logic [AW-1:0] bank_addr(input logic [IW-1:0] x, input logic [IW-1:0] y);
    bank_addr = AW'(32'(y >> 1) * HALF + 32'(x >> 1));
  endfunction

  always_comb begin
    logic [IW-1:0] xs, ys;
    for (int b = 0; b < 4; b++) begin
      xs = (e_x[0] == b[0]) ? e_x : e_x + IW'(1);
      ys = (e_y[0] == b[1]) ? e_y : e_y + IW'(1);
      rd_addr[b] = bank_addr(xs, ys);
    end
  end

  assign wr_addr = bank_addr(e_x, e_y);
  assign wr_bank = {e_y[0], e_x[0]};
  assign wr_en   = q_pop && (e_cmd == CMD_WRITE) && e_ok;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [VALUE_W-1:0] mem [BDEPTH];
    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(g))) mem[wr_addr] <= e_data;
      if (c_ready) rd_r[g] <= mem[rd_addr[g]];
    end
  end

  assign wp1 = {1'b0, c_p_r};
  assign wp0 = WEIGHT_ONE - wp1;
  assign wq1 = {1'b0, c_q_r};
  assign wq0 = WEIGHT_ONE - wq1;
  assign w00 = wp0 * wq0;
  assign w10 = wp1 * wq0;
  assign w01 = wp0 * wq1;
  assign w11 = wp1 * wq1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m_nxt[k] = $signed({1'b0, d_w_r[k]}) * d_val_r[k];
    end
  end

  assign sum = e_m_r[0] + e_m_r[1] + e_m_r[2] + e_m_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      // Write requests finish in the bank and leave the pipeline here.
      if (c_ready) c_v_r <= q_pop && (e_cmd == CMD_QUERY);
      if (d_ready) d_v_r <= c_v_r;
      if (e_ready) e_v_r <= d_v_r;
      if (o_ready) o_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_ok_r <= e_ok;
      c_x0_r <= e_x[0];
      c_y0_r <= e_y[0];
      c_p_r  <= e_p;
      c_q_r  <= e_q;
    end
    if (d_ready && c_v_r) begin
      d_ok_r     <= c_ok_r;
      d_w_r[0]   <= w00[32:0];
      d_w_r[1]   <= w10[32:0];
      d_w_r[2]   <= w01[32:0];
      d_w_r[3]   <= w11[32:0];
      d_val_r[0] <= $signed(rd_r[{c_y0_r, c_x0_r}]);
      d_val_r[1] <= $signed(rd_r[{c_y0_r, !c_x0_r}]);
      d_val_r[2] <= $signed(rd_r[{!c_y0_r, c_x0_r}]);
      d_val_r[3] <= $signed(rd_r[{!c_y0_r, !c_x0_r}]);
    end
    if (e_ready && d_v_r) begin
      e_ok_r <= d_ok_r;
      for (int k = 0; k < 4; k++) e_m_r[k] <= m_nxt[k][63:0];
    end
    if (o_ready && e_v_r) begin
      o_ok_r  <= e_ok_r;
      o_val_r <= e_ok_r ? sum[63:32] : '0;
    end
  end

  assign out_valid        = o_v_r;
  assign out_in_range     = o_ok_r;
  assign out_sample_value = o_val_r;

endmodule

FILE: sv/mesh_bilinear_sampler.sv
// Mesh bilinear sampler, top level: configuration registers, front end,
// request queue and back end. Uses msb_pkg, msb_front, msb_queue, msb_back.
//
// Requests arrive on the in_ channel (valid/stall). A write request stores
// in_cell_value at (in_cell_x, in_cell_y) and gives no result; a query request
// gives one result on the out_ channel: the bilinear blend of the four cells
// around (in_query_x, in_query_y), or zero with out_in_range low outside.
// The two registers (half extent, cell scale) must be written on the cfg_ port
// only while no request is in flight; the block itself does not enforce this.
// One request is accepted every cycle while in_stall is low. A query result
// passes in order through two front stages (offset add, scale multiply),
// one queue slot, then the bank read, weight multiply and tap multiply stages
// and the output register. The mesh sits in four parity banks with one read
// port each, so all four taps of a query are read in the same cycle.
// Reset clears the pipeline and queue and restores the register defaults;
// there is no clearing pass, and mesh cells read before being written hold
// unknown data. When out_stall is held the back end stops, the queue fills,
// and in_stall rises once the front stages are full.
module mesh_bilinear_sampler import msb_pkg::*; #(
  parameter int MESH_SIZE   = 128,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [6:0]                in_cell_x,
  input  logic [6:0]                in_cell_y,
  input  logic signed [VALUE_W-1:0] in_cell_value,
  input  logic signed [VALUE_W-1:0] in_query_x,
  input  logic signed [VALUE_W-1:0] in_query_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_sample_value,
  output logic                      out_in_range,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int IW = $clog2(MESH_SIZE);
  localparam int QW = 2 + 2 * IW + 2 * WEIGHT_W + VALUE_W;

  logic [CFG_W-1:0] half_extent_r, cell_scale_r;
  q_status_t        q_st;
  logic             q_push, q_pop;
  logic [QW-1:0]    push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_extent_r <= HALF_EXTENT_RST;
      cell_scale_r  <= CELL_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_EXTENT: half_extent_r <= cfg_data;
        REG_CELL_SCALE:  cell_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  msb_front #(.MESH_SIZE(MESH_SIZE), .IW(IW), .QW(QW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_value (in_cell_value),
    .in_query_x    (in_query_x),
    .in_query_y    (in_query_y),
    .half_extent   (half_extent_r),
    .cell_scale    (cell_scale_r),
    .q_st          (q_st),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  msb_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .st        (q_st)
  );

  msb_back #(.MESH_SIZE(MESH_SIZE), .IW(IW), .QW(QW)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_entry          (pop_entry),
    .q_st             (q_st),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_in_range     (out_in_range)
  );

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_sample_value == '0)
    else $error("result outside the mesh is not zero");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_st.full)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("request popped from an empty queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_st.full)
    else $error("input stalled while the queue has room");
`endif

endmodule

FILE: test/mesh_sample_checker.sv
// Checker for the mesh bilinear sampler: watches the request, result and register
// ports, keeps its own mesh and register copies and compares every result.
// Depends on msb_pkg for widths, commands and register indexes.
module mesh_sample_checker import msb_pkg::*; #(
  parameter int MESH = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_command,
  input  logic [6:0]                in_cell_x,
  input  logic [6:0]                in_cell_y,
  input  logic signed [VALUE_W-1:0] in_cell_value,
  input  logic signed [VALUE_W-1:0] in_query_x,
  input  logic signed [VALUE_W-1:0] in_query_y,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VALUE_W-1:0] out_sample_value,
  input  logic                      out_in_range,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        samples_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      in_range;
  } sample_t;

  logic signed [VALUE_W-1:0] mesh_copy [MESH*MESH];
  logic [CFG_W-1:0]          half_extent;
  logic [CFG_W-1:0]          cell_scale;
  sample_t                   sample_due [$];

  // Maps one coordinate to a grid index and a 16-bit weight; returns 0 when
  // the index falls outside the usable part of the mesh.
  function automatic logic axis_map(input logic signed [VALUE_W-1:0] coord,
                                    output int idx, output logic [WEIGHT_W-1:0] wt);
    longint prod;
    longint grid;
    idx = 0;
    wt  = '0;
    prod = (longint'(coord) + longint'(half_extent)) * longint'(cell_scale);
    if (prod < 0) return 1'b0;
    grid = (prod >>> 32) - 1;
    if (grid < 1 || grid > MESH - 2) return 1'b0;
    idx = int'(grid);
    wt  = prod[31:16];
    return 1'b1;
  endfunction

  function automatic longint tap(input int col, input int row);
    return longint'(mesh_copy[row*MESH + col]);
  endfunction

  function automatic sample_t blend_sample(input logic signed [VALUE_W-1:0] qx,
                                           input logic signed [VALUE_W-1:0] qy);
    sample_t             res;
    int                  ix, iy;
    logic [WEIGHT_W-1:0] p, q;
    logic                okx, oky;
    longint              wp0, wp1, wq0, wq1, acc;
    okx = axis_map(qx, ix, p);
    oky = axis_map(qy, iy, q);
    res.value    = '0;
    res.in_range = 1'b0;
    if (okx && oky) begin
      wp1 = longint'(p);
      wp0 = longint'(WEIGHT_ONE) - wp1;
      wq1 = longint'(q);
      wq0 = longint'(WEIGHT_ONE) - wq1;
      acc = wp0 * wq0 * tap(ix, iy) + wp1 * wq0 * tap(ix + 1, iy)
          + wp0 * wq1 * tap(ix, iy + 1) + wp1 * wq1 * tap(ix + 1, iy + 1);
      // Taking the upper word of the exact sum floors it by 2^32.
      res.value    = acc[63:32];
      res.in_range = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    sample_t due;
    if (!rst_n) begin
      sample_due.delete();
      half_extent  <= HALF_EXTENT_RST;
      cell_scale   <= CELL_SCALE_RST;
      fail_count   <= 0;
      samples_owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sample_due.size() == 0) begin
          $display("%0t: result with nothing owed: sample_value %h in_range %b",
                   $time, out_sample_value, out_in_range);
          fail_count <= fail_count + 1;
        end else begin
          due = sample_due.pop_front();
          if (out_sample_value !== due.value || out_in_range !== due.in_range) begin
            $display("%0t: mismatch: expected sample_value %h in_range %b, got %h %b",
                     $time, due.value, due.in_range, out_sample_value, out_in_range);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_command == CMD_WRITE) begin
          if (in_cell_x < MESH && in_cell_y < MESH)
            mesh_copy[in_cell_y*MESH + in_cell_x] = in_cell_value;
        end else begin
          sample_due.push_back(blend_sample(in_query_x, in_query_y));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_HALF_EXTENT) half_extent <= cfg_data;
        else cell_scale <= cfg_data;
      end
      samples_owed <= sample_due.size();
    end
  end

endmodule

FILE: test/mesh_bilinear_sampler_test.sv
// Top of the mesh bilinear sampler testbench: clock, reset, request stimulus,
// register settings, receiver stalls and the verdict.
// Depends on msb_pkg, mesh_bilinear_sampler and mesh_sample_checker.
module mesh_bilinear_sampler_test;
  import msb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MESH       = 128;
  localparam int PER_PHASE  = 28;
  localparam int SETTLE     = 16;
  localparam int HOLD_LEN   = 300;
  localparam int N_SETTINGS = 6;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_THIRD} stall_mode_t;

  typedef struct {
    logic [CFG_W-1:0] he;
    logic [CFG_W-1:0] cs;
  } setting_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_command = CMD_WRITE;
  logic [6:0]                in_cell_x = '0;
  logic [6:0]                in_cell_y = '0;
  logic signed [VALUE_W-1:0] in_cell_value = '0;
  logic signed [VALUE_W-1:0] in_query_x = '0;
  logic signed [VALUE_W-1:0] in_query_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_sample_value;
  logic                      out_in_range;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = REG_HALF_EXTENT;
  logic [CFG_W-1:0]          cfg_data = '0;
  int                        fail_count;
  int                        samples_owed;
  logic                      hold_req = 1'b0;

  logic [CFG_W-1:0] he_now = HALF_EXTENT_RST;
  logic [CFG_W-1:0] cs_now = CELL_SCALE_RST;
  bit               written [MESH*MESH];
  int               burst_left = 0;

  setting_t settings [N_SETTINGS] = '{
    '{31'h0002_0000, 31'h0020_0000},
    '{31'h7FFF_FFFF, 31'd1},
    '{31'd1,         31'h7FFF_FFFF},
    '{31'd0,         31'd0},
    '{31'h0002_8000, 31'h0019_9999},
    '{HALF_EXTENT_RST, CELL_SCALE_RST}
  };

  always #2 clk = ~clk;

  mesh_bilinear_sampler #(.MESH_SIZE(MESH)) dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_cell_x, .in_cell_y, .in_cell_value,
    .in_query_x, .in_query_y,
    .out_valid, .out_stall, .out_sample_value, .out_in_range,
    .cfg_we, .cfg_index, .cfg_data
  );

  mesh_sample_checker #(.MESH(MESH)) chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_cell_x, .in_cell_y, .in_cell_value,
    .in_query_x, .in_query_y,
    .out_valid, .out_stall, .out_sample_value, .out_in_range,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .samples_owed
  );

  // Grid index that a coordinate maps to under the current registers, or a
  // negative number when the scaled point is below zero.
  function automatic int grid_index(input logic signed [VALUE_W-1:0] coord);
    longint prod;
    prod = (longint'(coord) + longint'(he_now)) * longint'(cs_now);
    if (prod < 0) return -1;
    return int'(prod >>> 32) - 1;
  endfunction

  // Coordinate that lands near the given grid index with the given fraction.
  function automatic logic signed [VALUE_W-1:0] coord_at(input int idx,
                                                         input logic [31:0] frac);
    longint target, x;
    if (cs_now == 0) return $urandom;
    target = (longint'(idx + 1) <<< 32) + longint'(frac);
    x = target / longint'(cs_now) - longint'(he_now);
    if (x > 64'sh7FFF_FFFF) x = 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) x = -64'sh8000_0000;
    return x[31:0];
  endfunction

  task automatic drive(input logic cmd, input logic [6:0] cx, input logic [6:0] cy,
                       input logic signed [VALUE_W-1:0] v,
                       input logic signed [VALUE_W-1:0] qx,
                       input logic signed [VALUE_W-1:0] qy);
    int   gap;
    logic stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_cell_x     <= cx;
    in_cell_y     <= cy;
    in_cell_value <= v;
    in_query_x    <= qx;
    in_query_y    <= qy;
    // Stall is sampled mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_write(input int col, input int row, input logic signed [VALUE_W-1:0] v);
    written[row*MESH + col] = 1'b1;
    drive(CMD_WRITE, col[6:0], row[6:0], v, $urandom, $urandom);
  endtask

  // Cells a query would blend are written first, so no unwritten cell is read.
  task automatic send_query(input logic signed [VALUE_W-1:0] qx,
                            input logic signed [VALUE_W-1:0] qy);
    int ix, iy;
    ix = grid_index(qx);
    iy = grid_index(qy);
    if (ix >= 1 && ix <= MESH - 2 && iy >= 1 && iy <= MESH - 2) begin
      for (int dy = 0; dy < 2; dy++)
        for (int dx = 0; dx < 2; dx++)
          if (!written[(iy + dy)*MESH + ix + dx])
            send_write(ix + dx, iy + dy, $urandom);
    end
    drive(CMD_QUERY, 7'($urandom), 7'($urandom), $urandom, qx, qy);
  endtask

  task automatic random_value(output logic signed [VALUE_W-1:0] v);
    case ($urandom_range(0, 7))
      0:       v = 32'sh7FFF_FFFF;
      1:       v = 32'sh8000_0000;
      default: v = $urandom;
    endcase
  endtask

  // Registers change only once every owed result is out and the pipeline has
  // had time to finish trailing writes.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (samples_owed != 0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] he, input logic [CFG_W-1:0] cs);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_EXTENT;
    cfg_data  <= he;
    @(posedge clk);
    cfg_index <= REG_CELL_SCALE;
    cfg_data  <= cs;
    @(posedge clk);
    cfg_we <= 1'b0;
    he_now = he;
    cs_now = cs;
  endtask

  task automatic random_item();
    int                        pick;
    logic signed [VALUE_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      random_value(v);
      send_write($urandom_range(0, MESH - 1), $urandom_range(0, MESH - 1), v);
    end else if (pick < 85) begin
      send_query(coord_at($urandom_range(0, MESH + 1) - 1, $urandom),
                 coord_at($urandom_range(0, MESH + 1) - 1, $urandom));
    end else begin
      send_query($urandom, $urandom);
    end
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          hold;
    bit          hold_taken;
    mode       = STALL_NONE;
    mode_left  = 0;
    hold       = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(4, 60);
        end
        mode_left--;
        case (mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
          default:    out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #2ms;
    $display("FAIL mesh_bilinear_sampler");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Largest cell values around the low corner, blended at both weight ends, then the smallest.
    send_write(1, 1, 32'sh7FFF_FFFF);
    send_write(2, 1, 32'sh7FFF_FFFF);
    send_write(1, 2, 32'sh7FFF_FFFF);
    send_write(2, 2, 32'sh7FFF_FFFF);
    send_query(coord_at(1, 32'hFFFF_FFFF), coord_at(1, 32'hFFFF_FFFF));
    send_query(coord_at(1, 32'h0), coord_at(1, 32'h0));
    send_write(1, 1, 32'sh8000_0000);
    send_write(2, 1, 32'sh8000_0000);
    send_write(1, 2, 32'sh8000_0000);
    send_write(2, 2, 32'sh8000_0000);
    send_query(coord_at(1, 32'h8000_0000), coord_at(1, 32'hFFFF_FFFF));
    // Top corner of the usable mesh, and the indices just outside it.
    send_query(coord_at(MESH - 2, 32'hFFFF_FFFF), coord_at(MESH - 2, 32'hFFFF_FFFF));
    send_query(coord_at(0, 32'hFFFF_FFFF), coord_at(1, 32'h0));
    send_query(coord_at(1, 32'h0), coord_at(MESH - 1, 32'h0));
    // Extreme coordinates: far above the mesh and below zero; then writes to two outer corner cells.
    send_query(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_query(32'sh7FFF_FFFF, coord_at(2, 32'h4000_0000));
    send_query(coord_at(2, 32'h4000_0000), 32'sh8000_0000);
    send_write(MESH - 1, 0, 32'sh0);
    send_write(0, MESH - 1, 32'sh7FFF_FFFF);

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      drain();
      set_regs(settings[ph].he, settings[ph].cs);
      if (ph == 4) hold_req <= 1'b1;
      for (int n = 0; n < PER_PHASE; n++) random_item();
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS mesh_bilinear_sampler");
    end else begin
      $display("FAIL mesh_bilinear_sampler");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/msb_pkg.sv
sv/msb_front.sv
sv/msb_queue.sv
sv/msb_back.sv
sv/mesh_bilinear_sampler.sv
test/mesh_sample_checker.sv
test/mesh_bilinear_sampler_test.sv
